// ===== design/pfc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the packet framer.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    // Input word action codes.
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    localparam logic [7:0]  SYNC_BYTE = 8'h16;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

    // Longest run of output words one input word can cause.
    localparam int unsigned RUN_MAX = 7;
    localparam int unsigned RUN_W   = $clog2(RUN_MAX + 1);
    localparam int unsigned IDX_W   = $clog2(RUN_MAX);

    typedef struct packed {
        logic        action;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_in_run;
        logic       end_of_packet;
        logic       no_packet_error;
    } t_out_word;

    // All output words caused by one input word.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_W-1:0]        count;
        logic                    trailer;
        logic                    err;
    } t_run;

    // Reflected CRC-32 update for one byte, unrolled into an xor network.
    function automatic logic [31:0] crc32_fold_byte(input logic [31:0] crc,
                                                    input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/pfc_core.sv =====
// Framing state and the builder that turns one input word into a run of output bytes.
`timescale 1ns / 1ps
`default_nettype none

module pfc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire pfc_pkg::t_in_word i_word,
    output pfc_pkg::t_run          o_run
);
    import pfc_pkg::*;

    logic [31:0] r_crc, n_crc;
    logic [15:0] r_remaining, n_remaining;
    logic        r_open, n_open;

    logic [31:0] fold_crc;
    logic [31:0] final_crc;
    logic [15:0] rem_dec;

    assign fold_crc  = crc32_fold_byte(r_crc, i_word.data_byte);
    assign final_crc = fold_crc ^ CRC_INIT;
    assign rem_dec   = r_remaining - 16'd1;

    always_comb begin
        n_crc       = r_crc;
        n_remaining = r_remaining;
        n_open      = r_open;
        o_run       = '0;
        unique case (i_word.action)
            ACT_START: begin
                n_crc       = CRC_INIT;
                n_remaining = i_word.payload_length;
                n_open      = (i_word.payload_length != 16'd0);
                o_run.bytes[0] = SYNC_BYTE;
                o_run.bytes[1] = i_word.payload_length[15:8];
                o_run.bytes[2] = i_word.payload_length[7:0];
                if (i_word.payload_length != 16'd0) begin
                    o_run.count = RUN_W'(3);
                end else begin
                    // The empty payload has a CRC of zero; bytes 3 to 6 stay zero.
                    o_run.count   = RUN_W'(7);
                    o_run.trailer = 1'b1;
                end
            end
            ACT_PAYLOAD: begin
                if (!r_open) begin
                    o_run.count = RUN_W'(1);
                    o_run.err   = 1'b1;
                end else begin
                    o_run.bytes[0] = i_word.data_byte;
                    if (rem_dec != 16'd0) begin
                        n_crc       = fold_crc;
                        n_remaining = rem_dec;
                        o_run.count = RUN_W'(1);
                    end else begin
                        n_crc          = CRC_INIT;
                        n_remaining    = 16'd0;
                        n_open         = 1'b0;
                        o_run.bytes[1] = final_crc[31:24];
                        o_run.bytes[2] = final_crc[23:16];
                        o_run.bytes[3] = final_crc[15:8];
                        o_run.bytes[4] = final_crc[7:0];
                        o_run.count    = RUN_W'(5);
                        o_run.trailer  = 1'b1;
                    end
                end
            end
            default: begin
                o_run.count = RUN_W'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_remaining <= 16'd0;
            r_open      <= 1'b0;
        end else if (i_load) begin
            r_crc       <= n_crc;
            r_remaining <= n_remaining;
            r_open      <= n_open;
        end
    end

    // An open packet always expects at least one more byte.
    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_remaining != 16'd0))
        else $error("open packet with no bytes remaining");

    // With no packet open the CRC sits at its initial value.
    a_closed_crc_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_crc == CRC_INIT))
        else $error("CRC not reset while no packet is open");

endmodule

`default_nettype wire

// ===== design/pfc_out_seq.sv =====
// Output sequencer: holds one run of bytes and hands them out one word at a time.
`timescale 1ns / 1ps
`default_nettype none

module pfc_out_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_run_valid,
    input  wire pfc_pkg::t_run      i_run,
    output logic                    o_load,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pfc_pkg::t_out_word      o_out_word
);
    import pfc_pkg::*;

    logic             r_valid;
    t_run             r_run;
    logic [IDX_W-1:0] r_idx;
    logic             at_last;
    logic             take_next;

    assign at_last   = (r_idx == IDX_W'(r_run.count - RUN_W'(1)));
    assign take_next = !r_valid || (i_out_ready && at_last);
    assign o_load    = i_run_valid && take_next;

    assign o_out_valid                = r_valid;
    assign o_out_word.out_byte        = r_run.bytes[r_idx];
    assign o_out_word.last_in_run     = at_last;
    assign o_out_word.end_of_packet   = at_last && r_run.trailer;
    assign o_out_word.no_packet_error = r_run.err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_out_ready) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_run <= i_run;
        end
    end

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (RUN_W'(r_idx) < r_run.count))
        else $error("run index beyond run length");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_run.err) |-> (r_run.count == RUN_W'(1) && !r_run.trailer))
        else $error("error run longer than one word");

endmodule

`default_nettype wire

// ===== design/packet_framer_crc32.sv =====
// Top level of the length-prefixed packet framer with CRC-32 trailer.
// An accepted input word passes the input register, then the run register, before
// its first output word shows when the output side is free.
// Throughput: one input word per cycle while each word yields one output word and the
// receiver is ready; a start word yields three output words (seven for a zero-length
// packet) and the closing payload word five, handed out through the single output port.
// Reset is synchronous and active low: no words pending, CRC all ones, no packet open.
`timescale 1ns / 1ps
`default_nettype none

module packet_framer_crc32 (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pfc_pkg::t_in_word i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pfc_pkg::t_out_word     o_out_word
);
    import pfc_pkg::*;

    // Input register: holds one accepted word until the sequencer takes its run.
    logic     r_in_valid;
    t_in_word r_in_word;

    // High when the sequencer loads the run built from the held word; the
    // framing state advances on the same edge.
    logic load;
    t_run run;

    // A new word enters when the register is empty or is being drained this cycle,
    // so a payload stream moves at one word per cycle while the receiver is ready.
    assign o_in_ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    // The core builds the whole run for the held word in one pass of logic,
    // including the eight-step CRC byte update.
    pfc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_word  (r_in_word),
        .o_run   (run)
    );

    // The sequencer owns the output handshake and steps through the run.
    pfc_out_seq u_out_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (r_in_valid),
        .i_run       (run),
        .o_load      (load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // A held word that is not taken stays put.
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !load) |=> (r_in_valid && $stable(r_in_word)))
        else $error("held input word lost or changed");

    // The sequencer never loads without a word in the input register.
    a_load_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> r_in_valid)
        else $error("run loaded from an empty input register");

endmodule

`default_nettype wire

// ===== tb/sv/packet_framer_crc32_test.sv =====
// Self-checking testbench for the length-prefixed packet framer with CRC-32 trailer.
`timescale 1ns / 1ps

module packet_framer_crc32_test;

    import pfc_pkg::*;

    // Receiver hold-off used by the backpressure test. It is long enough for the
    // framer to fill up and stall its input several times over.
    localparam int HOLD_OFF_CYCLES = 60;
    // Quiet cycles after the last expected word, well above what the input and run
    // registers plus the longest run of seven output words take.
    localparam int DRAIN_CYCLES = 24;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    packet_framer_crc32 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Expected output words, oldest first.
    t_out_word framed_bytes_q[$];

    // The framer as the testbench sees it: running CRC before the final xor,
    // payload bytes still owed to the open packet, and whether one is open.
    logic [31:0] crc_state;
    logic [15:0] bytes_left;
    logic        pkt_open;

    int  mismatch_count;
    int  words_sent;
    bit  idle_on;
    bit  hold_off_req;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Reflected CRC-32, one data bit per step: the feedback bit is the low
    // bit of the register xored with the incoming data bit, least significant
    // data bit first.
    function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] r;
        logic        fb;
        r = crc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ data[k];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void queue_word(input logic [7:0] b, input logic last,
                                       input logic eop, input logic err);
        t_out_word w;
        w.out_byte        = b;
        w.last_in_run     = last;
        w.end_of_packet   = eop;
        w.no_packet_error = err;
        framed_bytes_q.push_back(w);
    endfunction

    // The trailer carries the complemented CRC, most significant byte first,
    // and closes the packet.
    function automatic void queue_trailer();
        logic [31:0] final_crc;
        final_crc = crc_state ^ CRC_INIT;
        queue_word(final_crc[31:24], 1'b0, 1'b0, 1'b0);
        queue_word(final_crc[23:16], 1'b0, 1'b0, 1'b0);
        queue_word(final_crc[15:8],  1'b0, 1'b0, 1'b0);
        queue_word(final_crc[7:0],   1'b1, 1'b1, 1'b0);
        crc_state  = CRC_INIT;
        bytes_left = 16'd0;
        pkt_open   = 1'b0;
    endfunction

    // Works out every output word that one accepted input word causes.
    function automatic void predict_frame(input t_in_word w);
        if (w.action == ACT_START) begin
            // A start always restarts the CRC, even over an unfinished packet.
            crc_state  = CRC_INIT;
            bytes_left = w.payload_length;
            pkt_open   = (w.payload_length != 16'd0);
            queue_word(SYNC_BYTE, 1'b0, 1'b0, 1'b0);
            queue_word(w.payload_length[15:8], 1'b0, 1'b0, 1'b0);
            queue_word(w.payload_length[7:0], pkt_open, 1'b0, 1'b0);
            if (!pkt_open) begin
                queue_trailer();
            end
        end else if (!pkt_open) begin
            // A stray payload byte leaves the state alone.
            queue_word(8'h00, 1'b1, 1'b0, 1'b1);
        end else begin
            crc_state  = crc32_next(crc_state, w.data_byte);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left != 16'd0) begin
                queue_word(w.data_byte, 1'b1, 1'b0, 1'b0);
            end else begin
                queue_word(w.data_byte, 1'b0, 1'b0, 1'b0);
                queue_trailer();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("%0t ns: %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    endtask

    // Outputs are sampled at the rising edge, before any update of that edge
    // lands, so the handshake seen here is the one the framer sees.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (framed_bytes_q.size() == 0) begin
                report_mismatch("word with nothing expected", o_out_word.out_byte, 8'h00);
            end else begin
                want = framed_bytes_q.pop_front();
                if (o_out_word.out_byte !== want.out_byte) begin
                    report_mismatch("out_byte", o_out_word.out_byte, want.out_byte);
                end
                if (o_out_word.last_in_run !== want.last_in_run) begin
                    report_mismatch("last_in_run", 8'(o_out_word.last_in_run),
                                    8'(want.last_in_run));
                end
                if (o_out_word.end_of_packet !== want.end_of_packet) begin
                    report_mismatch("end_of_packet", 8'(o_out_word.end_of_packet),
                                    8'(want.end_of_packet));
                end
                if (o_out_word.no_packet_error !== want.no_packet_error) begin
                    report_mismatch("no_packet_error", 8'(o_out_word.no_packet_error),
                                    8'(want.no_packet_error));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // The receiver takes words freely, stalls in short random bursts while
    // idling is on, and on request holds off for a long counted stretch.
    initial begin : out_side
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 4);
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one word and returns at the edge where it is taken. Valid is left
    // high on return, so a following word goes out back to back; an idle gap
    // lowers it only in a time step where nothing else drives it.
    task automatic send_word(input logic act, input logic [15:0] len, input logic [7:0] data);
        t_in_word w;
        int       gap;
        w.action         = act;
        w.payload_length = len;
        w.data_byte      = data;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_frame(w);
        words_sent++;
    endtask

    // A start word for len bytes followed by count payload words. The unused
    // field of each word carries random bits, which the framer must ignore.
    task automatic send_packet(input logic [15:0] len, input int count);
        send_word(ACT_START, len, 8'($urandom_range(0, 255)));
        for (int k = 0; k < count; k++) begin
            send_word(ACT_PAYLOAD, 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A payload byte straight after reset has no packet to go to.
    task automatic test_stray_byte();
        send_word(ACT_PAYLOAD, 16'h0000, 8'hA5);
    endtask

    // An empty packet closes at once with an all-zero CRC; a byte after it is
    // stray again.
    task automatic test_empty_packet();
        send_word(ACT_START, 16'h0000, 8'hFF);
        send_word(ACT_PAYLOAD, 16'hFFFF, 8'h3C);
    endtask

    // The largest length opens a packet that is then abandoned by a new start;
    // a one-byte packet then closes normally with the extreme byte values.
    task automatic test_length_extremes();
        send_word(ACT_START, 16'hFFFF, 8'h00);
        send_word(ACT_PAYLOAD, 16'h0000, 8'hFF);
        send_word(ACT_PAYLOAD, 16'hFFFF, 8'h00);
        send_word(ACT_PAYLOAD, 16'h1234, 8'h5A);
        send_word(ACT_START, 16'h0100, 8'h81);
        send_word(ACT_PAYLOAD, 16'h0000, 8'h01);
        send_word(ACT_START, 16'h0001, 8'h00);
        send_word(ACT_PAYLOAD, 16'h0000, 8'hFF);
    endtask

    // The usual nine-character check string, whose CRC-32 is well known.
    task automatic test_check_string();
        string s;
        s = "123456789";
        send_word(ACT_START, 16'd9, 8'h00);
        for (int k = 0; k < s.len(); k++) begin
            send_word(ACT_PAYLOAD, 16'h0000, s[k]);
        end
    endtask

    // The receiver holds off for a long stretch while short packets keep
    // coming, so the framer backs up and has to stall its input.
    task automatic test_output_backpressure();
        hold_off_req = 1'b1;
        for (int p = 0; p < 10; p++) begin
            send_packet(16'd2, 2);
        end
    endtask

    // Mostly well-formed packets of random content, plus short packets that
    // are cut off by the next start and stray bytes between packets.
    task automatic test_random_packets(input int quota);
        int first;
        int pick;
        int len;
        first = words_sent;
        while (words_sent - first < quota) begin
            // Switch idling off now and then so that some stretches run at
            // full rate on both sides.
            idle_on = ($urandom_range(0, 9) < 7);
            pick    = $urandom_range(0, 99);
            if (pick < 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(1, 6);
                send_packet(16'(len), len);
            end else if (pick < 80) begin
                send_packet(16'd0, 0);
            end else if (pick < 90) begin
                // Cut short: the next start abandons it.
                len = $urandom_range(2, 65535);
                send_packet(16'(len), $urandom_range(0, 3));
            end else begin
                send_word(ACT_PAYLOAD, 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)));
            end
        end
        // Close anything left open so the next part starts from a clean packet.
        send_packet(16'd1, 1);
    endtask

    // The last stretch runs with no idling on either side.
    task automatic test_full_rate_tail();
        idle_on = 1'b0;
        for (int p = 0; p < 8; p++) begin
            send_packet(16'($urandom_range(1, 4)), 0);
            for (int k = int'(bytes_left); k > 0; k--) begin
                send_word(ACT_PAYLOAD, 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)));
            end
        end
        send_word(ACT_PAYLOAD, 16'h0000, 8'h77);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        crc_state      = CRC_INIT;
        bytes_left     = 16'd0;
        pkt_open       = 1'b0;
        mismatch_count = 0;
        words_sent     = 0;
        idle_on        = 1'b1;
        hold_off_req   = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stray_byte();
        test_empty_packet();
        test_length_extremes();
        test_check_string();
        test_output_backpressure();
        test_random_packets(90);
        test_full_rate_tail();

        i_in_valid <= 1'b0;
        while (framed_bytes_q.size() != 0) @(posedge i_clk);
        // Anything that shows up now is a word with nothing expected.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && framed_bytes_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // A stalled handshake must not hang the run.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
